[rtl/core/lcm_pkg.sv]
// Shared constants and controller/datapath interface types for the LCM block.
package lcm_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);

  typedef enum logic {
    DIV_GCD,
    DIV_QUO
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_step;
    logic     euclid_swap;
    logic     mul_start;
    logic     mul_step;
    logic     capture;
  } cmd_t;

  typedef struct packed {
    logic y_zero;
    logic op_zero;
    logic step_last;
  } status_t;

endpackage

[rtl/core/lcm_via_euclid_gcd.sv]
// Top level of the LCM block: Euclid GCD followed by a divide and a multiply.
//
// Each input transfer carries two unsigned 32-bit operands and yields exactly one result
// transfer holding their greatest common divisor, the low 32 bits of their least common
// multiple (computed as operand_a / gcd * operand_b) and an overflow flag that is set when
// the true multiple does not fit in 32 bits. A zero operand gives the other operand as the
// divisor and a multiple of 0 with no overflow. The block works on one operand pair at a
// time; all arithmetic runs through one restoring divider and one shift-add multiplier,
// each retiring one bit per cycle. An item runs a chain of Euclid remainder steps (each a
// full division plus setup and swap), followed by one division for the quotient and a
// multiply; the chain has at most about 46 steps for 32-bit operands, and an item with a
// zero operand skips the quotient divide and the multiply. A finished result sits in an
// output register, so the next operand pair is taken while that result still waits for
// its transfer.
module lcm_via_euclid_gcd (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lcm_pkg::OPERAND_WIDTH-1:0] operand_a_i,
  input  logic [lcm_pkg::OPERAND_WIDTH-1:0] operand_b_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lcm_pkg::OPERAND_WIDTH-1:0] common_multiple_o,
  output logic [lcm_pkg::OPERAND_WIDTH-1:0] common_divisor_o,
  output logic                             overflow_o
);
  import lcm_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  cmd_t    cmd;
  status_t status;

  lcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the operands, the Euclid pair, the shared divider, the multiplier
  // and the result registers that drive the output ports.
  lcm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .operand_a_i       (operand_a_i),
    .operand_b_i       (operand_b_i),
    .common_multiple_o (common_multiple_o),
    .common_divisor_o  (common_divisor_o),
    .overflow_o        (overflow_o)
  );

endmodule

[rtl/core/lcm_datapath.sv]
// Datapath of the LCM block: operand registers, shared divider, multiplier, result registers.
module lcm_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lcm_pkg::cmd_t                    cmd_i,
  output lcm_pkg::status_t                 status_o,
  input  logic [lcm_pkg::OPERAND_WIDTH-1:0] operand_a_i,
  input  logic [lcm_pkg::OPERAND_WIDTH-1:0] operand_b_i,
  output logic [lcm_pkg::OPERAND_WIDTH-1:0] common_multiple_o,
  output logic [lcm_pkg::OPERAND_WIDTH-1:0] common_divisor_o,
  output logic                             overflow_o
);
  import lcm_pkg::*;

  localparam int W = OPERAND_WIDTH;

  logic [W-1:0]     a_q, b_q, x_q, y_q;
  logic [W-1:0]     rem_q;
  logic [W-1:0]     quo_q, dvs_q;
  logic [W-1:0]     hi_q, lo_q, mcand_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     res_mult_q, res_gcd_q;
  logic             res_ovf_q;

  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;
  logic [W:0]       acc;

  // One restoring division bit per step.
  assign trial = {rem_q, quo_q[W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};
  // One shift-add multiply bit per step.
  assign acc   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start || cmd_i.mul_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step || cmd_i.mul_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= operand_a_i;
      b_q <= operand_b_i;
      x_q <= operand_a_i;
      y_q <= operand_b_i;
    end
    if (cmd_i.euclid_swap) begin
      x_q <= y_q;
      y_q <= rem_q;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      if (cmd_i.div_sel == DIV_GCD) begin
        quo_q <= x_q;
        dvs_q <= y_q;
      end else begin
        quo_q <= a_q;
        dvs_q <= x_q;
      end
    end else if (cmd_i.div_step) begin
      if (fits) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_start) begin
      hi_q    <= '0;
      lo_q    <= b_q;
      mcand_q <= quo_q;
    end else if (cmd_i.mul_step) begin
      hi_q <= acc[W:1];
      lo_q <= {acc[0], lo_q[W-1:1]};
    end
    if (cmd_i.capture) begin
      res_gcd_q <= x_q;
      if (status_o.op_zero) begin
        res_mult_q <= '0;
        res_ovf_q  <= 1'b0;
      end else begin
        res_mult_q <= lo_q;
        res_ovf_q  <= (hi_q != '0);
      end
    end
  end

  assign status_o.y_zero    = (y_q == '0);
  assign status_o.op_zero   = (a_q == '0) || (b_q == '0);
  assign status_o.step_last = (cnt_q == CNT_W'(W - 1));

  assign common_multiple_o = res_mult_q;
  assign common_divisor_o  = res_gcd_q;
  assign overflow_o        = res_ovf_q;

endmodule

[rtl/core/lcm_ctrl.sv]
// Controller state machine of the LCM block.
module lcm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lcm_pkg::status_t  status_i,
  output lcm_pkg::cmd_t     cmd_o
);
  import lcm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_GDIV  = 3'd2;
  localparam logic [2:0] S_SWAP  = 3'd3;
  localparam logic [2:0] S_QDIV  = 3'd4;
  localparam logic [2:0] S_MINIT = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status_i.y_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_GCD;
          state_d         = S_GDIV;
        end else if (status_i.op_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_QUO;
          state_d         = S_QDIV;
        end
      end
      S_GDIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd_o.euclid_swap = 1'b1;
        state_d           = S_CHECK;
      end
      S_QDIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_MINIT;
        end
      end
      S_MINIT: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.capture ? 1'b1 : (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_CHECK))
    else $error("load did not lead to the check state");
  a_gcd_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GDIV) |-> !status_i.y_zero)
    else $error("remainder step with a zero divisor");
  a_capture_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before its transfer");
  a_capture_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_q)
    else $error("captured result not presented");
`endif

endmodule

[bench/lcm_via_euclid_gcd_test.sv]
// Self-checking testbench for the LCM block: directed operand table, then random pairs.
module lcm_via_euclid_gcd_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = lcm_pkg::OPERAND_WIDTH;

  // The watchdog fires after this many cycles in which neither channel moves a transfer.
  // The slowest pair comes from consecutive Fibonacci numbers, and the receiver never
  // stalls for long, so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT  = 20000;
  // After the last result arrives, wait this long to catch any stray extra result.
  localparam int unsigned DRAIN_CYCLES = 2000;
  localparam int unsigned RANDOM_PAIRS = 830;
  localparam int unsigned N_DIRECTED   = 22;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t multiple;
    word_t divisor;
    logic  ovf;
  } lcm_result_t;

  typedef struct packed {
    word_t       a;
    word_t       b;
    logic        typed;   // 1: use the result written in the row, 0: use the predictor
    lcm_result_t want;
  } stim_row_t;

  // Directed rows. Results are typed in only where they are obvious by inspection; the
  // rest (overflowing products, long Euclid chains, odd bit patterns) go to the predictor.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Both operands zero, and a single zero operand on either side.
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 32'h0000_0001, 1'b0}},
    // Equal operands, including the largest value.
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0000_0001, 1'b0}},
    '{32'h0000_0007, 32'h0000_0007, 1'b1, '{32'h0000_0007, 32'h0000_0007, 1'b0}},
    '{32'h0001_0000, 32'h0001_0000, 1'b1, '{32'h0001_0000, 32'h0001_0000, 1'b0}},
    // One operand equal to one, then a small pair with a common divisor.
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0}},
    '{32'd12,        32'd18,        1'b1, '{32'd36,        32'd6,         1'b0}},
    // Multiples exactly at all ones (the widest without overflow) and at the top bit.
    '{32'd65535,     32'd65537,     1'b1, '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0}},
    '{32'h8000_0000, 32'h0000_0002, 1'b1, '{32'h8000_0000, 32'h0000_0002, 1'b0}},
    // Just past the top of the range, and far past it.
    '{32'd65536,     32'd65537,     1'b0, '0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
    '{32'h8000_0000, 32'h0000_0003, 1'b0, '0},
    // Consecutive Fibonacci numbers give the longest Euclid chain, in both orders.
    '{32'd2971215073, 32'd1836311903, 1'b0, '0},
    '{32'd1836311903, 32'd2971215073, 1'b0, '0},
    // One operand a multiple of the other, in both orders; the last pair is neither.
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  word_t operand_a_i;
  word_t operand_b_i;
  logic  out_valid_o;
  logic  out_ready_i;
  word_t common_multiple_o;
  word_t common_divisor_o;
  logic  overflow_o;

  lcm_via_euclid_gcd u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operand_a_i       (operand_a_i),
    .operand_b_i       (operand_b_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .common_multiple_o (common_multiple_o),
    .common_divisor_o  (common_divisor_o),
    .overflow_o        (overflow_o)
  );

  // Results still owed by the block, oldest first.
  lcm_result_t pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned pairs_sent;
  int unsigned results_seen;
  int unsigned overflow_seen;
  int unsigned zero_operand_seen;
  int unsigned quiet_cycles;

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operand_a_i = '0;
    operand_b_i = '0;
    out_ready_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // Predicted result of one operand pair. Euclid's remainder loop runs at double width so
  // the quotient times the second operand can be formed in full; anything above the
  // operand width marks an overflow and only the low bits are kept.
  function automatic lcm_result_t lcm_of(word_t a, word_t b);
    logic [2*W-1:0] x;
    logic [2*W-1:0] y;
    logic [2*W-1:0] r;
    logic [2*W-1:0] prod;
    lcm_result_t    res;
    x = {{W{1'b0}}, a};
    y = {{W{1'b0}}, b};
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    res.divisor  = x[W-1:0];
    res.multiple = '0;
    res.ovf      = 1'b0;
    // A zero operand has no multiple to speak of; the block reports 0 without overflow.
    if (a != '0 && b != '0) begin
      prod         = ({{W{1'b0}}, a} / x) * {{W{1'b0}}, b};
      res.ovf      = (prod[2*W-1:W] != '0);
      res.multiple = prod[W-1:0];
    end
    return res;
  endfunction

  // Offers one operand pair and returns at the edge where the transfer happens. The valid
  // is only lowered for an idle gap, so back-to-back pairs keep it high without a glitch.
  task automatic send_pair(input word_t a, input word_t b, input lcm_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(want);
    pairs_sent++;
  endtask

  // Idle schedule across the run: a lazy receiver first, then a lazy sender, then a last
  // stretch where both sides run flat out.
  task automatic pick_idle_phase();
    if (pairs_sent < (N_DIRECTED + RANDOM_PAIRS) / 3) begin
      send_idle_pct = 12;
      recv_idle_pct = 49;
    end else if (pairs_sent < 2 * (N_DIRECTED + RANDOM_PAIRS) / 3) begin
      send_idle_pct = 49;
      recv_idle_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Receiver side: checks every result transfer against the oldest expectation, then
  // decides whether to stall on the next cycle. The handshake is sampled at the edge,
  // before any of this edge's register updates land.
  always @(posedge clk_i) begin
    lcm_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (overflow_o === 1'b1) overflow_seen++;
      if (common_multiple_o === '0 && overflow_o === 1'b0) zero_operand_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing pending: mult=%h div=%h ovf=%b",
                   $realtime, common_multiple_o, common_divisor_o, overflow_o);
      end else begin
        want = pending_results.pop_front();
        if (common_multiple_o !== want.multiple || common_divisor_o !== want.divisor ||
            overflow_o !== want.ovf) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"[%0t] result %0d: expected mult=%h div=%h ovf=%b, ",
                      "got mult=%h div=%h ovf=%b"},
                     $realtime, results_seen, want.multiple, want.divisor, want.ovf,
                     common_multiple_o, common_divisor_o, overflow_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hang on either channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, pending_results.size());
      $display("lcm_via_euclid_gcd test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    word_t          a;
    word_t          b;
    word_t          g;
    lcm_result_t    want;
    int unsigned    kind;
    int unsigned    n;
    logic [W-1:0]   fib_hi;
    logic [W-1:0]   fib_lo;
    logic [W-1:0]   fib_next;

    mismatches        = 0;
    pairs_sent        = 0;
    results_seen      = 0;
    overflow_seen     = 0;
    zero_operand_seen = 0;
    quiet_cycles      = 0;
    pick_idle_phase();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table first.
    for (int i = 0; i < N_DIRECTED; i++) begin
      pick_idle_phase();
      want = DIRECTED[i].typed ? DIRECTED[i].want : lcm_of(DIRECTED[i].a, DIRECTED[i].b);
      send_pair(DIRECTED[i].a, DIRECTED[i].b, want);
    end

    // Random pairs. Full-width pairs are the slow ones, so they are a minority; most pairs
    // are narrower or built around a shared factor, which exercises short Euclid chains and
    // divisors other than one.
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      pick_idle_phase();
      kind = $urandom_range(99);
      if (kind < 28) begin
        a = $urandom;
        b = $urandom;
      end else if (kind < 48) begin
        // Shared factor times two cofactors; the divisor is usually the factor itself.
        g = ($urandom >> $urandom_range(16, 31)) | 1;
        a = g * ($urandom >> $urandom_range(12, 31));
        b = g * ($urandom >> $urandom_range(12, 31));
      end else if (kind < 64) begin
        a = $urandom >> $urandom_range(0, 31);
        b = $urandom >> $urandom_range(0, 31);
      end else if (kind < 71) begin
        // A zero on one side or both.
        n = $urandom_range(2);
        a = (n == 1) ? ($urandom >> $urandom_range(0, 31)) : '0;
        b = (n == 0) ? ($urandom >> $urandom_range(0, 31)) : '0;
      end else if (kind < 77) begin
        a = $urandom >> $urandom_range(0, 31);
        b = a;
      end else if (kind < 84) begin
        // Powers of two, sometimes nudged by one, around the overflow boundary.
        a = 32'd1 << $urandom_range(0, 31);
        b = (32'd1 << $urandom_range(0, 31)) + $urandom_range(2) - 1;
      end else if (kind < 91) begin
        // Consecutive Fibonacci numbers: the worst case for the remainder loop.
        n = $urandom_range(2, 47);
        fib_hi = 1;
        fib_lo = 1;
        for (int k = 2; k < n; k++) begin
          fib_next = fib_hi + fib_lo;
          fib_lo   = fib_hi;
          fib_hi   = fib_next;
        end
        if ($urandom_range(1)) begin
          a = fib_hi;
          b = fib_lo;
        end else begin
          a = fib_lo;
          b = fib_hi;
        end
      end else begin
        // Values close to the top of the range.
        a = ~word_t'($urandom_range(255));
        b = $urandom_range(1) ? ~word_t'($urandom_range(255)) : $urandom;
      end
      send_pair(a, b, lcm_of(a, b));
    end
    in_valid_i <= 1'b0;

    // Let every owed result come back, then watch a while longer for extras.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d operand pairs (%0d from the table, %0d random) under three idle phases.",
             pairs_sent, N_DIRECTED, RANDOM_PAIRS);
    $display("Checked %0d results: %0d with overflow, %0d with a zero multiple; %0d mismatches.",
             results_seen, overflow_seen, zero_operand_seen, mismatches);
    if (mismatches == 0) begin
      $display("lcm_via_euclid_gcd test passed");
    end else begin
      $display("lcm_via_euclid_gcd test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lcm_pkg.sv
rtl/core/lcm_datapath.sv
rtl/core/lcm_ctrl.sv
rtl/core/lcm_via_euclid_gcd.sv
bench/lcm_via_euclid_gcd_test.sv
